// ----- sv/swcm_pkg.sv -----
// shared constants, types and helpers for the swirl coordinate map
package swcm_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int CFG_BITS   = 13;
   localparam int Q30        = 30;

   localparam int QUO_BITS  = 2 * COORD_BITS + 5;
   localparam int NORM_BITS = FRAC_BITS + 1;
   localparam int R2_BITS   = 2 * FRAC_BITS;
   localparam int REM_BITS  = FRAC_BITS + 2;
   localparam int HW        = Q30 + 1;
   localparam int RCP_BITS  = 32;
   localparam int K_BITS    = 7;
   localparam int UT_BITS   = NORM_BITS + 3;
   localparam int NUM_BITS  = UT_BITS + CFG_BITS + 2;
   localparam int DEN_BITS  = NUM_BITS - FRAC_BITS - 1;

   localparam int COS_TERMS = 5;
   localparam int SIN_TERMS = 4;
   localparam int DIV_LAT   = QUO_BITS;
   localparam int SQRT_LAT  = FRAC_BITS;
   localparam int SC_LAT    = 3 * COS_TERMS + 1;

   localparam logic [K_BITS-1:0] COS_K [COS_TERMS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
   localparam logic [K_BITS-1:0] SIN_K [SIN_TERMS] = '{7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [RCP_BITS-1:0] COS_RCP [COS_TERMS] = '{
      32'(64'h1_0000_0000 / 64'd90), 32'(64'h1_0000_0000 / 64'd56),
      32'(64'h1_0000_0000 / 64'd30), 32'(64'h1_0000_0000 / 64'd12),
      32'(64'h1_0000_0000 / 64'd2)};
   localparam logic [RCP_BITS-1:0] SIN_RCP [SIN_TERMS] = '{
      32'(64'h1_0000_0000 / 64'd72), 32'(64'h1_0000_0000 / 64'd42),
      32'(64'h1_0000_0000 / 64'd20), 32'(64'h1_0000_0000 / 64'd6)};

   typedef enum logic [0:0] {
      REG_FRAME_HEIGHT = 1'b0,
      REG_FRAME_WIDTH  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]       row;
      logic [COORD_BITS-1:0]       col;
      logic signed [NORM_BITS-1:0] u;
      logic signed [NORM_BITS-1:0] v;
      logic                        ok;
   } side_type;

   // floor(x / k) from y = x * floor(2^32 / k), which is low by at most one
   function automatic logic [HW-1:0] quo_fix(input logic [HW-1:0] x,
                                             input logic [HW+RCP_BITS-1:0] y,
                                             input logic [K_BITS-1:0] k);
      logic [HW-1:0]        q0;
      logic [HW+K_BITS-1:0] rem;
      q0  = y[HW+RCP_BITS-1:RCP_BITS];
      rem = {{K_BITS{1'b0}}, x} - ({{K_BITS{1'b0}}, q0} * {{HW{1'b0}}, k});
      return q0 + HW'(rem >= {{HW{1'b0}}, k});
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_hi(input logic [DEN_BITS-1:0] v,
                                                      input logic [COORD_BITS-1:0] hi);
      return (v > {{(DEN_BITS-COORD_BITS){1'b0}}, hi}) ? hi : v[COORD_BITS-1:0];
   endfunction

endpackage

// ----- sv/swcm_div.sv -----
// pipelined restoring divider, one quotient bit per stage: (num << FRAC_BITS+1) / den
module swcm_div (
   input  logic                              clock,
   input  logic                              en,
   input  logic [swcm_pkg::COORD_BITS-1:0]   num_i,
   input  logic [swcm_pkg::CFG_BITS-1:0]     den_i,
   output logic [swcm_pkg::QUO_BITS-1:0]     quo_o
);
   import swcm_pkg::*;

   logic [COORD_BITS-1:0] num_ff [DIV_LAT];
   logic [CFG_BITS-1:0]   rem_ff [DIV_LAT];
   logic [QUO_BITS-1:0]   quo_ff [DIV_LAT];
   logic [COORD_BITS-1:0] num_in [DIV_LAT];
   logic [CFG_BITS-1:0]   rem_in [DIV_LAT];
   logic [QUO_BITS-1:0]   quo_in [DIV_LAT];

   always_comb begin
      for (int k = 0; k < DIV_LAT; k++) begin
         logic [COORD_BITS-1:0] n;
         logic [CFG_BITS-1:0]   r;
         logic [QUO_BITS-1:0]   q;
         logic [CFG_BITS:0]     rt;
         logic                  ge;
         n = (k == 0) ? num_i : num_ff[(k == 0) ? 0 : k-1];
         r = (k == 0) ? '0 : rem_ff[(k == 0) ? 0 : k-1];
         q = (k == 0) ? '0 : quo_ff[(k == 0) ? 0 : k-1];
         rt = {r, n[COORD_BITS-1]};
         ge = (rt >= {1'b0, den_i});
         num_in[k] = {n[COORD_BITS-2:0], 1'b0};
         rem_in[k] = ge ? CFG_BITS'(rt - {1'b0, den_i}) : rt[CFG_BITS-1:0];
         quo_in[k] = {q[QUO_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quo_o = quo_ff[DIV_LAT-1];

endmodule

// ----- sv/swcm_sincos.sv -----
// pipelined sine and cosine by truncated taylor series in horner form, q30 inside
module swcm_sincos (
   input  logic                             clock,
   input  logic                             en,
   input  logic [swcm_pkg::HW-1:0]          t_i,
   input  logic [swcm_pkg::HW-1:0]          t2_i,
   output logic [swcm_pkg::NORM_BITS-1:0]   sin_o,
   output logic [swcm_pkg::NORM_BITS-1:0]   cos_o
);
   import swcm_pkg::*;

   localparam logic [HW-1:0] ONE_Q  = HW'(1) << Q30;
   localparam logic [HW-1:0] HALF_Q = HW'(1) << (Q30 - FRAC_BITS - 1);
   localparam int CARRY = 3 * SIN_TERMS;

   logic [HW-1:0]          t2_ff [CARRY];
   logic [HW-1:0]          t_ff  [CARRY];
   logic [HW-1:0]          cx_ff [COS_TERMS];
   logic [HW-1:0]          cxq_ff [COS_TERMS];
   logic [HW+RCP_BITS-1:0] cy_ff [COS_TERMS];
   logic [HW-1:0]          ch_ff [COS_TERMS];
   logic [HW-1:0]          sx_ff [SIN_TERMS];
   logic [HW-1:0]          sxq_ff [SIN_TERMS];
   logic [HW+RCP_BITS-1:0] sy_ff [SIN_TERMS];
   logic [HW-1:0]          sh_ff [SIN_TERMS];
   logic [HW-1:0]          sm_ff;
   logic [HW-1:0]          sd1_ff;
   logic [HW-1:0]          sd2_ff;
   logic [NORM_BITS-1:0]   sin_ff;
   logic [NORM_BITS-1:0]   cos_ff;

   logic [HW-1:0]          cx_in [COS_TERMS];
   logic [HW-1:0]          sx_in [SIN_TERMS];
   logic [2*HW-1:0]        sm_prod;
   logic [HW-1:0]          sin_sum;
   logic [HW-1:0]          cos_sum;

   always_comb begin
      for (int j = 0; j < COS_TERMS; j++) begin
         logic [2*HW-1:0] p;
         logic [HW-1:0]   ts;
         logic [HW-1:0]   hp;
         ts = (j == 0) ? t2_i : t2_ff[(j == 0) ? 0 : 3*j-1];
         hp = (j == 0) ? ONE_Q : ch_ff[(j == 0) ? 0 : j-1];
         p = ts * hp;
         cx_in[j] = p[Q30+HW-1:Q30];
      end
      for (int j = 0; j < SIN_TERMS; j++) begin
         logic [2*HW-1:0] p;
         logic [HW-1:0]   ts;
         logic [HW-1:0]   hp;
         ts = (j == 0) ? t2_i : t2_ff[(j == 0) ? 0 : 3*j-1];
         hp = (j == 0) ? ONE_Q : sh_ff[(j == 0) ? 0 : j-1];
         p = ts * hp;
         sx_in[j] = p[Q30+HW-1:Q30];
      end
      sm_prod = t_ff[CARRY-1] * sh_ff[SIN_TERMS-1];
      sin_sum = sd2_ff + HALF_Q;
      cos_sum = ch_ff[COS_TERMS-1] + HALF_Q;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t2_ff[0] <= t2_i;
         t_ff[0]  <= t_i;
         for (int k = 1; k < CARRY; k++) begin
            t2_ff[k] <= t2_ff[k-1];
            t_ff[k]  <= t_ff[k-1];
         end
         for (int j = 0; j < COS_TERMS; j++) begin
            cx_ff[j]  <= cx_in[j];
            cy_ff[j]  <= cx_ff[j] * COS_RCP[j];
            cxq_ff[j] <= cx_ff[j];
            ch_ff[j]  <= ONE_Q - quo_fix(cxq_ff[j], cy_ff[j], COS_K[j]);
         end
         for (int j = 0; j < SIN_TERMS; j++) begin
            sx_ff[j]  <= sx_in[j];
            sy_ff[j]  <= sx_ff[j] * SIN_RCP[j];
            sxq_ff[j] <= sx_ff[j];
            sh_ff[j]  <= ONE_Q - quo_fix(sxq_ff[j], sy_ff[j], SIN_K[j]);
         end
         sm_ff  <= sm_prod[Q30+HW-1:Q30];
         sd1_ff <= sm_ff;
         sd2_ff <= sd1_ff;
         sin_ff <= sin_sum[HW-1:Q30-FRAC_BITS];
         cos_ff <= cos_sum[HW-1:Q30-FRAC_BITS];
      end
   end

   assign sin_o = sin_ff;
   assign cos_o = cos_ff;

endmodule

// ----- sv/swirl_warp_coordinate_map.sv -----
// swirl inverse coordinate map: output pixel to clamped source pixel
// throughput: one beat per cycle; the whole pipeline advances together and holds on stall
// depth: normalizing divider 29 stages, square root 16, sine and cosine 16, plus 8 glue stages
// reset clears the valid bits and loads frame height 480 and frame width 640
module swirl_warp_coordinate_map (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,   // out_row, out_col
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,   // src_row, src_col
   output logic [0:0]                          rsp_tuser,   // in_swirl
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [0:0]                          csr_index,
   input  logic [swcm_pkg::CFG_BITS-1:0]       csr_data
);
   import swcm_pkg::*;

   localparam int ST_A     = DIV_LAT;
   localparam int ST_B     = ST_A + 1;
   localparam int SQ0      = ST_B + 1;
   localparam int ST_D     = SQ0 + SQRT_LAT;
   localparam int ST_E     = ST_D + 1;
   localparam int SC0      = ST_E + 1;
   localparam int ST_R1    = SC0 + SC_LAT;
   localparam int ST_R2    = ST_R1 + 1;
   localparam int ST_R3    = ST_R2 + 1;
   localparam int ST_OUT   = ST_R3 + 1;
   localparam int N_STAGES = ST_OUT + 1;

   localparam logic [NORM_BITS-1:0]  ONE_N   = NORM_BITS'(1) << FRAC_BITS;
   localparam logic [CFG_BITS-1:0]   MAX_CRD = CFG_BITS'((1 << COORD_BITS) - 1);
   localparam logic [UT_BITS:0]      ONE_U   = (UT_BITS+1)'(1) << FRAC_BITS;

   logic [CFG_BITS-1:0]   height_ff, width_ff;
   logic [CFG_BITS-1:0]   hgt, wid;
   logic [COORD_BITS-1:0] hi_row, hi_col;
   logic                  en;

   logic [N_STAGES-1:0]   vld_ff;
   side_type              side_ff [N_STAGES];
   side_type              side_in [N_STAGES];

   logic [QUO_BITS-1:0]   quo_row, quo_col;
   logic signed [NORM_BITS-1:0]   u_a, v_a;
   logic signed [2*NORM_BITS-1:0] uu_p, vv_p;
   logic [R2_BITS:0]      uu_ff, vv_ff;
   logic [R2_BITS+1:0]    r2_sum;
   logic [R2_BITS-1:0]    r2_ff;

   logic [REM_BITS-1:0]   sq_rem_ff  [SQRT_LAT];
   logic [FRAC_BITS-1:0]  sq_root_ff [SQRT_LAT];
   logic [R2_BITS-1:0]    sq_rad_ff  [SQRT_LAT];
   logic [REM_BITS-1:0]   sq_rem_in  [SQRT_LAT];
   logic [FRAC_BITS-1:0]  sq_root_in [SQRT_LAT];
   logic [R2_BITS-1:0]    sq_rad_in  [SQRT_LAT];

   logic [NORM_BITS-1:0]   d_w;
   logic [2*NORM_BITS-1:0] dd_p, th2_p;
   logic [NORM_BITS-1:0]   theta_ff;
   logic [HW-1:0]          t_ff, t2_ff;
   logic [NORM_BITS-1:0]   sin_w, cos_w;

   logic signed [2*NORM_BITS:0] cu_ff, sv_ff, su_ff, cv_ff;
   logic signed [2*NORM_BITS+1:0] ut_sum, vt_sum;
   logic signed [UT_BITS-1:0]   ut_ff, vt_ff;
   logic signed [UT_BITS:0]     ut_off, vt_off;
   logic signed [NUM_BITS-1:0]  numr_ff, numc_ff;
   logic [DEN_BITS-1:0]         denr, denc;

   logic [COORD_BITS-1:0] src_row_ff, src_col_ff;
   logic                  in_swirl_ff;

   // config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= CFG_BITS'(480);
         width_ff  <= CFG_BITS'(640);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_FRAME_HEIGHT: height_ff <= csr_data;
            REG_FRAME_WIDTH:  width_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign hgt    = (height_ff == '0) ? CFG_BITS'(1) : height_ff;
   assign wid    = (width_ff == '0) ? CFG_BITS'(1) : width_ff;
   assign hi_row = ((hgt - 1'b1) > MAX_CRD) ? MAX_CRD[COORD_BITS-1:0]
                                             : COORD_BITS'(hgt - 1'b1);
   assign hi_col = ((wid - 1'b1) > MAX_CRD) ? MAX_CRD[COORD_BITS-1:0]
                                             : COORD_BITS'(wid - 1'b1);

   // global advance
   assign en         = !vld_ff[N_STAGES-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N_STAGES-2:0], req_tvalid};
      end
   end

   swcm_div u_div_row (
      .clock (clock),
      .en    (en),
      .num_i (req_tdata[COORD_BITS-1:0]),
      .den_i (hgt),
      .quo_o (quo_row)
   );

   swcm_div u_div_col (
      .clock (clock),
      .en    (en),
      .num_i (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .den_i (wid),
      .quo_o (quo_col)
   );

   assign u_a    = $signed(quo_row[NORM_BITS-1:0] - ONE_N);
   assign v_a    = $signed(quo_col[NORM_BITS-1:0] - ONE_N);
   assign uu_p   = u_a * u_a;
   assign vv_p   = v_a * v_a;
   assign r2_sum = {1'b0, uu_ff} + {1'b0, vv_ff};

   always_comb begin
      for (int k = 0; k < N_STAGES; k++) begin
         if (k == 0) begin
            side_in[k].row = req_tdata[COORD_BITS-1:0];
            side_in[k].col = req_tdata[2*COORD_BITS-1:COORD_BITS];
            side_in[k].u   = '0;
            side_in[k].v   = '0;
            side_in[k].ok  = 1'b0;
         end else begin
            side_in[k] = side_ff[(k == 0) ? 0 : k-1];
         end
      end
      side_in[ST_A].u  = u_a;
      side_in[ST_A].v  = v_a;
      side_in[ST_A].ok = (quo_row[QUO_BITS-1:NORM_BITS] == '0)
                      && (quo_col[QUO_BITS-1:NORM_BITS] == '0);
      side_in[ST_B].ok = side_ff[ST_A].ok && (r2_sum[R2_BITS+1:R2_BITS] == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
      end
   end

   // square root, one result bit per stage
   always_comb begin
      for (int k = 0; k < SQRT_LAT; k++) begin
         logic [REM_BITS-1:0]  r;
         logic [FRAC_BITS-1:0] q;
         logic [R2_BITS-1:0]   a;
         logic [REM_BITS+1:0]  rt;
         logic [REM_BITS+1:0]  trial;
         logic                 ge;
         r = (k == 0) ? '0 : sq_rem_ff[(k == 0) ? 0 : k-1];
         q = (k == 0) ? '0 : sq_root_ff[(k == 0) ? 0 : k-1];
         a = (k == 0) ? r2_ff : sq_rad_ff[(k == 0) ? 0 : k-1];
         rt    = {r, a[R2_BITS-1:R2_BITS-2]};
         trial = {2'b00, q, 2'b01};
         ge    = (rt >= trial);
         sq_rem_in[k]  = ge ? REM_BITS'(rt - trial) : rt[REM_BITS-1:0];
         sq_root_in[k] = {q[FRAC_BITS-2:0], ge};
         sq_rad_in[k]  = {a[R2_BITS-3:0], 2'b00};
      end
   end

   assign d_w   = ONE_N - {1'b0, sq_root_ff[SQRT_LAT-1]};
   assign dd_p  = d_w * d_w;
   assign th2_p = theta_ff * theta_ff;

   swcm_sincos u_sincos (
      .clock (clock),
      .en    (en),
      .t_i   (t_ff),
      .t2_i  (t2_ff),
      .sin_o (sin_w),
      .cos_o (cos_w)
   );

   assign ut_sum = (2*NORM_BITS+2)'(cu_ff) - (2*NORM_BITS+2)'(sv_ff);
   assign vt_sum = (2*NORM_BITS+2)'(su_ff) + (2*NORM_BITS+2)'(cv_ff);
   assign ut_off = (UT_BITS+1)'(ut_ff) + $signed(ONE_U);
   assign vt_off = (UT_BITS+1)'(vt_ff) + $signed(ONE_U);
   assign denr   = (numr_ff <= 0) ? '0 : DEN_BITS'(numr_ff >>> (FRAC_BITS + 1));
   assign denc   = (numc_ff <= 0) ? '0 : DEN_BITS'(numc_ff >>> (FRAC_BITS + 1));

   always_ff @(posedge clock) begin
      if (en) begin
         uu_ff      <= uu_p[R2_BITS:0];
         vv_ff      <= vv_p[R2_BITS:0];
         r2_ff      <= r2_sum[R2_BITS-1:0];
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
         sq_rad_ff  <= sq_rad_in;
         theta_ff   <= dd_p[2*FRAC_BITS:FRAC_BITS];
         t_ff       <= {theta_ff, {(Q30-FRAC_BITS){1'b0}}};
         t2_ff      <= th2_p[HW+1:2];
         cu_ff      <= $signed({1'b0, cos_w}) * side_ff[ST_R1-1].u;
         sv_ff      <= $signed({1'b0, sin_w}) * side_ff[ST_R1-1].v;
         su_ff      <= $signed({1'b0, sin_w}) * side_ff[ST_R1-1].u;
         cv_ff      <= $signed({1'b0, cos_w}) * side_ff[ST_R1-1].v;
         ut_ff      <= UT_BITS'(ut_sum >>> FRAC_BITS);
         vt_ff      <= UT_BITS'(vt_sum >>> FRAC_BITS);
         numr_ff    <= NUM_BITS'(ut_off * $signed({1'b0, hgt}));
         numc_ff    <= NUM_BITS'(vt_off * $signed({1'b0, wid}));
         if (side_ff[ST_OUT-1].ok) begin
            src_row_ff <= clamp_hi(denr, hi_row);
            src_col_ff <= clamp_hi(denc, hi_col);
         end else begin
            src_row_ff <= clamp_hi(DEN_BITS'(side_ff[ST_OUT-1].row), hi_row);
            src_col_ff <= clamp_hi(DEN_BITS'(side_ff[ST_OUT-1].col), hi_col);
         end
         in_swirl_ff <= side_ff[ST_OUT-1].ok;
      end
   end

   assign rsp_tvalid = vld_ff[N_STAGES-1];
   assign rsp_tdata  = {src_col_ff, src_row_ff};
   assign rsp_tuser  = in_swirl_ff;

`ifndef NO_ASSERTIONS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while the result is stalled");

   a_sqrt_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_D-1] |-> ({1'b0, sq_rem_ff[SQRT_LAT-1]}
                          <= {2'b00, sq_root_ff[SQRT_LAT-1], 1'b0}))
      else $error("square root remainder out of range");

   a_square_bound: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_A] && side_ff[ST_A].ok) |-> (uu_ff <= ((R2_BITS+1)'(1) << R2_BITS)))
      else $error("normalized square out of range");
`endif

endmodule
